// ===== design/brqs_pkg.sv =====
// Shared types and codes for the buffer and rate based quality selector.
package brqs_pkg;

  // Request kinds carried in the input tuser field
  localparam logic [1:0] ACT_SAMPLE   = 2'd0;
  localparam logic [1:0] ACT_DECIDE   = 2'd1;
  localparam logic [1:0] ACT_LOAD     = 2'd2;
  localparam logic [1:0] ACT_RESERVED = 2'd3;  // unused, ignored

  // Configuration register indexes
  localparam logic [2:0] CFG_ALPHA     = 3'd0;
  localparam logic [2:0] CFG_SLACK     = 3'd1;
  localparam logic [2:0] CFG_RESERVOIR = 3'd2;
  localparam logic [2:0] CFG_UPPER     = 3'd3;
  localparam logic [2:0] CFG_RUNS      = 3'd4;
  localparam logic [2:0] CFG_LEVELS    = 3'd5;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_MUL,
    ST_AVG_SUM,
    ST_LIMIT,
    ST_SWEEP,
    ST_DECIDE
  } state_t;

  // Search token handed from cell to cell along the ladder
  typedef struct packed {
    logic        any;    // some earlier cell was in use
    logic        done1;  // instant bound found
    logic [31:0] phi1;   // instant-rate bound so far
    logic        done2;  // average bound found
    logic [31:0] phi2;   // average-rate bound so far
  } token_t;

endpackage

// ===== design/brqs_cell.sv =====
// One ladder cell: holds one bitrate entry and advances the bound search token.
module brqs_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [31:0]     wr_data,
  input  logic            in_use,
  input  logic [47:0]     lim1,
  input  logic [47:0]     lim2,
  input  logic            tok_in_valid,
  input  brqs_pkg::token_t tok_in,
  output logic            tok_out_valid,
  output brqs_pkg::token_t tok_out,
  output logic [31:0]     entry
);

  brqs_pkg::token_t tok_next;
  logic [47:0]      scaled;
  logic             ex1;
  logic             ex2;

  // Ladder entry, no reset: undefined until loaded
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_data;
    end
  end

  // entry * 4096 against the slack-scaled rates
  assign scaled = {4'b0000, entry, 12'h000};
  assign ex1    = scaled > lim1;
  assign ex2    = scaled > lim2;

  // Bound search step
  always_comb begin
    tok_next = tok_in;
    if (in_use) begin
      tok_next.any = 1'b1;
      if (!tok_in.done1) begin
        if (ex1) begin
          tok_next.done1 = 1'b1;
          if (!tok_in.any) begin
            tok_next.phi1 = entry;
          end
        end else begin
          tok_next.phi1 = entry;
        end
      end
      if (!tok_in.done2) begin
        if (ex2) begin
          tok_next.done2 = 1'b1;
          if (!tok_in.any) begin
            tok_next.phi2 = entry;
          end
        end else begin
          tok_next.phi2 = entry;
        end
      end
    end
  end

  // Token valid travels one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_valid <= 1'b0;
    end else begin
      tok_out_valid <= tok_in_valid;
    end
  end

  // Token payload holds once the token has passed
  always_ff @(posedge clk) begin
    if (tok_in_valid) begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== design/buffer_rate_quality_selector_top.sv =====
// Top level of the buffer and rate based quality selector.
//
//  channel   dir  handshake          payload
//  s_axis    in   s_tvalid/s_tready  s_tuser action, s_tdata rate/fill/slot
//  m_axis    out  m_tvalid/m_tready  m_tdata chosen level and rate
//  cfg       in   cfg_we             cfg_index, cfg_data
//
// A bandwidth sample passes through accept, average multiply and average sum
// (two-product average update); a ladder load is taken at accept alone. A
// decision steps through accept, limit multiply, the sweep in which the search
// token walks the chain one cell at a time until it leaves the chain, then the
// decision itself. Reset is synchronous; ladder entries are undefined until
// loaded and get no clearing pass. Samples and loads are taken while a result
// waits on m_axis; a decision waits in its decision state for the output.
module buffer_rate_quality_selector_top #(
  parameter int MAX_LEVELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // s_tuser: action[1:0]
  input  logic [1:0]  s_tuser,
  // s_tdata: rate_value[31:0], buffer_fill[45:32], level_index[48:46], zero pad
  input  logic [55:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // m_tdata: chosen_level[2:0], chosen_rate[34:3], zero pad
  output logic [39:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int QW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int NW = $clog2(MAX_LEVELS + 1);
  localparam int CW = (NW > 4) ? NW : 4;

  // Configuration registers
  logic [15:0] smoothing_alpha;
  logic [15:0] rate_slack;
  logic [13:0] reservoir_level;
  logic [13:0] upper_level;
  logic [7:0]  step_up_runs;
  logic [3:0]  levels_in_use;

  // Selector state
  logic [31:0]   instant_rate;
  logic [31:0]   average_rate;
  logic [QW-1:0] quality_level;
  logic [7:0]    favorable_runs;
  logic [31:0]   current_rate;

  // Work registers
  brqs_pkg::state_t state;
  brqs_pkg::state_t state_next;
  logic [31:0]   sample;
  logic [13:0]   fill;
  logic [47:0]   p_old;
  logic [48:0]   p_new;
  logic [47:0]   lim1;
  logic [47:0]   lim2;
  logic [NW-1:0] n_reg;
  logic          launch;
  logic [2:0]    chosen_level;
  logic [31:0]   chosen_rate;

  // Input fields
  logic [31:0] rate_value;
  logic [13:0] buffer_fill;
  logic [2:0]  level_index;
  logic        in_fire;
  logic        out_free;

  assign rate_value  = s_tdata[31:0];
  assign buffer_fill = s_tdata[45:32];
  assign level_index = s_tdata[48:46];
  assign in_fire     = s_tvalid && s_tready;
  assign out_free    = !m_tvalid || m_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_alpha <= 16'd52429;
      rate_slack      <= 16'd3277;
      reservoir_level <= 14'd2000;
      upper_level     <= 14'd8000;
      step_up_runs    <= 8'd2;
      levels_in_use   <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        brqs_pkg::CFG_ALPHA:     smoothing_alpha <= cfg_data;
        brqs_pkg::CFG_SLACK:     rate_slack      <= cfg_data;
        brqs_pkg::CFG_RESERVOIR: reservoir_level <= cfg_data[13:0];
        brqs_pkg::CFG_UPPER:     upper_level     <= cfg_data[13:0];
        brqs_pkg::CFG_RUNS:      step_up_runs    <= cfg_data[7:0];
        brqs_pkg::CFG_LEVELS:    levels_in_use   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Levels in use clamped to 1..MAX_LEVELS
  logic [CW-1:0] liu_ext;
  logic [NW-1:0] n_clamped;
  always_comb begin
    liu_ext = CW'(levels_in_use);
    if (liu_ext == '0) begin
      n_clamped = NW'(1);
    end else if (liu_ext > CW'(MAX_LEVELS)) begin
      n_clamped = NW'(MAX_LEVELS);
    end else begin
      n_clamped = NW'(liu_ext);
    end
  end

  // Ladder chain
  logic             tok_valid [MAX_LEVELS+1];
  brqs_pkg::token_t tok       [MAX_LEVELS+1];
  logic [31:0]      entries   [MAX_LEVELS];
  logic             load_ok;

  assign tok_valid[0] = launch;
  assign tok[0]       = '0;
  assign load_ok      = in_fire && (s_tuser == brqs_pkg::ACT_LOAD) &&
                        (32'(level_index) < 32'(MAX_LEVELS));

  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
    brqs_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .wr_en         (load_ok && (32'(level_index) == 32'(i))),
      .wr_data       (rate_value),
      .in_use        (32'(i) < 32'(n_reg)),
      .lim1          (lim1),
      .lim2          (lim2),
      .tok_in_valid  (tok_valid[i]),
      .tok_in        (tok[i]),
      .tok_out_valid (tok_valid[i+1]),
      .tok_out       (tok[i+1]),
      .entry         (entries[i])
    );
  end

  // Decision from the two bounds
  logic [31:0]   phi1;
  logic [31:0]   phi2;
  logic [QW-1:0] last;
  logic [QW-1:0] q_cl;
  logic [QW-1:0] q_next;
  logic [7:0]    runs_inc;
  logic [7:0]    runs_next;
  logic [QW+2:0] q_wide;

  assign phi1 = tok[MAX_LEVELS].phi1;
  assign phi2 = tok[MAX_LEVELS].phi2;
  assign last = QW'(n_reg - NW'(1));

  always_comb begin
    q_cl      = (NW'(quality_level) >= n_reg) ? last : quality_level;
    q_next    = q_cl;
    runs_next = favorable_runs;
    runs_inc  = (favorable_runs != 8'hFF) ? favorable_runs + 8'd1 : favorable_runs;
    if (fill < reservoir_level) begin
      runs_next = 8'd0;
      q_next    = '0;
    end else if (fill < upper_level) begin
      runs_next = 8'd0;
      if (current_rate > phi1) begin
        if (q_cl != '0) begin
          q_next = q_cl - QW'(1);
        end
      end else if (current_rate < phi1) begin
        if (q_cl < last) begin
          q_next = q_cl + QW'(1);
        end
      end
    end else if (current_rate < phi2) begin
      runs_next = runs_inc;
      if (runs_inc >= step_up_runs && q_cl < last) begin
        runs_next = 8'd0;
        q_next    = q_cl + QW'(1);
      end
    end
    q_wide = (QW+3)'(q_next);
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      brqs_pkg::ST_IDLE: begin
        s_tready = !rst;
        if (in_fire) begin
          case (s_tuser)
            brqs_pkg::ACT_SAMPLE: state_next = brqs_pkg::ST_AVG_MUL;
            brqs_pkg::ACT_DECIDE: state_next = brqs_pkg::ST_LIMIT;
            default:              state_next = brqs_pkg::ST_IDLE;
          endcase
        end
      end
      brqs_pkg::ST_AVG_MUL: state_next = brqs_pkg::ST_AVG_SUM;
      brqs_pkg::ST_AVG_SUM: state_next = brqs_pkg::ST_IDLE;
      brqs_pkg::ST_LIMIT:   state_next = brqs_pkg::ST_SWEEP;
      brqs_pkg::ST_SWEEP: begin
        if (tok_valid[MAX_LEVELS]) begin
          state_next = brqs_pkg::ST_DECIDE;
        end
      end
      brqs_pkg::ST_DECIDE: begin
        if (out_free) begin
          state_next = brqs_pkg::ST_IDLE;
        end
      end
      default: state_next = brqs_pkg::ST_IDLE;
    endcase
  end

  // Average accumulator: alpha*old + (1-alpha)*sample, rounded
  logic [49:0] avg_acc;
  assign avg_acc = 50'(p_old) + 50'(p_new) + 50'd32768;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= brqs_pkg::ST_IDLE;
      launch         <= 1'b0;
      m_tvalid       <= 1'b0;
      instant_rate   <= '0;
      average_rate   <= '0;
      quality_level  <= '0;
      favorable_runs <= '0;
      current_rate   <= '0;
    end else begin
      state  <= state_next;
      launch <= (state == brqs_pkg::ST_LIMIT);
      // Result valid: set by a committed decision, cleared when taken
      if (state == brqs_pkg::ST_DECIDE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (in_fire && s_tuser == brqs_pkg::ACT_SAMPLE) begin
        instant_rate <= rate_value;
      end
      if (state == brqs_pkg::ST_AVG_SUM) begin
        if (average_rate == '0) begin
          average_rate <= sample;
        end else begin
          average_rate <= avg_acc[47:16];
        end
      end
      if (state == brqs_pkg::ST_DECIDE && out_free) begin
        quality_level  <= q_next;
        favorable_runs <= runs_next;
        current_rate   <= entries[q_next];
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample <= rate_value;
      fill   <= buffer_fill;
    end
    if (state == brqs_pkg::ST_AVG_MUL) begin
      p_old <= 48'(smoothing_alpha) * 48'(average_rate);
      p_new <= 49'(17'h10000 - 17'(smoothing_alpha)) * 49'(sample);
    end
    if (state == brqs_pkg::ST_LIMIT) begin
      lim1  <= 48'(rate_slack) * 48'(instant_rate);
      lim2  <= 48'(rate_slack) * 48'(average_rate);
      n_reg <= n_clamped;
    end
    if (state == brqs_pkg::ST_DECIDE && out_free) begin
      chosen_level <= q_wide[2:0];
      chosen_rate  <= entries[q_next];
    end
  end

  assign m_tdata = {5'b00000, chosen_rate, chosen_level};

  // The search token reaches the chain end only during a sweep
  a_tok_in_sweep: assert property (@(posedge clk) disable iff (rst)
    tok_valid[MAX_LEVELS] |-> state == brqs_pkg::ST_SWEEP)
    else $error("search token left the chain outside a sweep");

  // The limit cycle always launches a token into the first cell
  a_launch: assert property (@(posedge clk) disable iff (rst)
    state == brqs_pkg::ST_LIMIT |=> tok_valid[0] && state == brqs_pkg::ST_SWEEP)
    else $error("no token launched after limit computation");

  // A new result appears only out of the decision state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == brqs_pkg::ST_DECIDE)
    else $error("result raised outside a decision");

  // A committed quality stays inside the ladder in use
  a_quality_range: assert property (@(posedge clk) disable iff (rst)
    (state == brqs_pkg::ST_DECIDE && out_free) |=> NW'(quality_level) < n_reg)
    else $error("quality level beyond levels in use");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking stream testbench for the buffer and rate based quality selector.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEVELS     = 8;
  localparam int DRAIN_CYCLES   = 2 * (MAX_LEVELS + 4);
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_SET = 68;

  typedef struct {
    logic [1:0]  act;
    logic [31:0] rate;
    logic [13:0] fill;
    logic [2:0]  slot;
  } quality_req_t;

  typedef struct {
    logic [2:0]  level;
    logic [31:0] rate;
  } level_choice_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [1:0]  s_tuser = '0;
  logic [55:0] s_tdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  buffer_rate_quality_selector_top #(.MAX_LEVELS(MAX_LEVELS)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Selector model: configuration copy
  logic [15:0] alpha_q     = 16'd52429;
  logic [15:0] slack_q     = 16'd3277;
  logic [13:0] reservoir_q = 14'd2000;
  logic [13:0] upper_q     = 14'd8000;
  logic [7:0]  runs_need_q = 8'd2;
  logic [3:0]  levels_q    = 4'd8;

  // Selector model: rate and quality state
  logic [31:0] inst_rate = '0;
  logic [31:0] avg_rate  = '0;
  logic [31:0] cur_rate  = '0;
  logic [2:0]  quality   = '0;
  logic [7:0]  fav_runs  = '0;
  logic [31:0] rungs [MAX_LEVELS];

  quality_req_t  pending_reqs [$];
  level_choice_t choices_due [$];
  int            fail_count = 0;

  logic req_taken  = 1'b0;
  logic resp_taken = 1'b0;
  int   gap_left   = 0;
  int   stall_left = 0;
  int   calm_src   = 0;
  int   calm_snk   = 0;
  int   quiet_cycles = 0;

  // Levels in use, with zero and oversize values folded into range
  function automatic int rungs_used();
    int n;
    n = int'(levels_q);
    if (n == 0) n = 1;
    if (n > MAX_LEVELS) n = MAX_LEVELS;
    return n;
  endfunction

  // Highest ladder entry that fits the slack-scaled rate
  function automatic logic [31:0] ladder_bound(input logic [31:0] rate, input int n);
    logic [63:0] lim;
    lim = 64'(slack_q) * 64'(rate);
    for (int i = 0; i < n; i++)
      if ((64'(rungs[i]) << 12) > lim) return rungs[(i == 0) ? 0 : i - 1];
    return rungs[n - 1];
  endfunction

  // Quality decision on a buffer update
  task automatic pick_level(input logic [13:0] fill);
    int          n;
    int          q;
    logic [31:0] phi1;
    logic [31:0] phi2;
    n    = rungs_used();
    phi1 = ladder_bound(inst_rate, n);
    phi2 = ladder_bound(avg_rate, n);
    q    = int'(quality);
    if (q >= n) q = n - 1;
    if (fill < reservoir_q) begin
      fav_runs = '0;
      q = 0;
    end else if (fill < upper_q) begin
      fav_runs = '0;
      if (cur_rate > phi1) begin
        if (q > 0) q--;
      end else if (cur_rate < phi1) begin
        if (q < n - 1) q++;
      end
    end else if (cur_rate < phi2) begin
      if (fav_runs < 8'd255) fav_runs++;
      if (fav_runs >= runs_need_q && q < n - 1) begin
        fav_runs = '0;
        q++;
      end
    end
    quality  = q[2:0];
    cur_rate = rungs[q];
  endtask

  // Model update for one accepted request
  task automatic apply_request(input quality_req_t r);
    logic [63:0]   acc;
    level_choice_t c;
    case (r.act)
      brqs_pkg::ACT_SAMPLE: begin
        inst_rate = r.rate;
        if (avg_rate == 0) begin
          avg_rate = r.rate;
        end else begin
          acc = 64'(alpha_q) * 64'(avg_rate) + (64'd65536 - 64'(alpha_q)) * 64'(r.rate)
              + 64'd32768;
          avg_rate = acc[47:16];
        end
      end
      brqs_pkg::ACT_LOAD: rungs[r.slot] = r.rate;
      brqs_pkg::ACT_DECIDE: begin
        pick_level(r.fill);
        c.level = quality;
        c.rate  = cur_rate;
        choices_due.push_back(c);
      end
      default: ;
    endcase
  endtask

  // Wait count per item, with occasional runs of back-to-back items
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 17);
  endfunction

  // Request driver
  always @(negedge clk) begin
    quality_req_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !req_taken) begin
      // hold until taken
    end else if (gap_left > 0) begin
      s_tvalid <= 1'b0;
      gap_left--;
    end else if (pending_reqs.size() > 0) begin
      r = pending_reqs.pop_front();
      s_tuser  <= r.act;
      s_tdata  <= {7'd0, r.slot, r.fill, r.rate};
      s_tvalid <= 1'b1;
      gap_left = draw_wait(calm_src);
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Result receiver backpressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (resp_taken) stall_left = draw_wait(calm_snk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    quality_req_t  r;
    level_choice_t want;
    logic [2:0]    got_level;
    logic [31:0]   got_rate;
    req_taken  <= s_tvalid && s_tready && !rst;
    resp_taken <= m_tvalid && m_tready && !rst;
    if (!rst && s_tvalid && s_tready) begin
      r.act  = s_tuser;
      r.rate = s_tdata[31:0];
      r.fill = s_tdata[45:32];
      r.slot = s_tdata[48:46];
      apply_request(r);
    end
    if (!rst && m_tvalid && m_tready) begin
      got_level = m_tdata[2:0];
      got_rate  = m_tdata[34:3];
      if (choices_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual level %0d rate %0d",
                 $time, got_level, got_rate);
        fail_count++;
      end else begin
        want = choices_due.pop_front();
        if (got_level !== want.level) begin
          $display("%0t: chosen_level mismatch, expected %0d actual %0d",
                   $time, want.level, got_level);
          fail_count++;
        end
        if (got_rate !== want.rate) begin
          $display("%0t: chosen_rate mismatch, expected %0d actual %0d",
                   $time, want.rate, got_rate);
          fail_count++;
        end
      end
    end
    // Watchdog on handshake activity
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Register write, mirrored into the model
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      brqs_pkg::CFG_ALPHA:     alpha_q     = val;
      brqs_pkg::CFG_SLACK:     slack_q     = val;
      brqs_pkg::CFG_RESERVOIR: reservoir_q = val[13:0];
      brqs_pkg::CFG_UPPER:     upper_q     = val[13:0];
      brqs_pkg::CFG_RUNS:      runs_need_q = val[7:0];
      brqs_pkg::CFG_LEVELS:    levels_q    = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] alpha, input logic [15:0] slack,
                          input logic [15:0] res, input logic [15:0] up,
                          input logic [15:0] runs, input logic [15:0] lev);
    write_reg(brqs_pkg::CFG_ALPHA, alpha);
    write_reg(brqs_pkg::CFG_SLACK, slack);
    write_reg(brqs_pkg::CFG_RESERVOIR, res);
    write_reg(brqs_pkg::CFG_UPPER, up);
    write_reg(brqs_pkg::CFG_RUNS, runs);
    write_reg(brqs_pkg::CFG_LEVELS, lev);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Block idle: all requests taken, all results in, trailing work finished
  task automatic settle();
    while (pending_reqs.size() > 0 || s_tvalid) @(posedge clk);
    while (choices_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_req(input logic [1:0] act, input logic [31:0] rate,
                           input logic [13:0] fill, input logic [2:0] slot);
    quality_req_t r;
    r.act  = act;
    r.rate = rate;
    r.fill = fill;
    r.slot = slot;
    pending_reqs.push_back(r);
  endtask

  // Fill near a threshold, kept inside the legal range
  function automatic logic [13:0] fill_near(input int center);
    int f;
    f = center + int'($urandom_range(0, 6)) - 3;
    if (f < 0) f = 0;
    if (f > 10000) f = 10000;
    return f[13:0];
  endfunction

  // Mostly samples, decisions and ladder reloads with realistic rates, some noise
  task automatic queue_random(input int count);
    int          pick;
    logic [2:0]  slot;
    logic [31:0] rate;
    logic [13:0] fill;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      slot = 3'($urandom_range(0, 7));
      fill = 14'($urandom_range(0, 10000));
      if (pick < 40) begin
        rate = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(50000, 20000000);
        queue_req(brqs_pkg::ACT_SAMPLE, rate, fill, slot);
      end else if (pick < 85) begin
        case ($urandom_range(0, 4))
          0: fill = fill_near(int'(reservoir_q));
          1: fill = fill_near(int'(upper_q));
          2: fill = 14'($urandom_range(0, 10000));
          3: fill = 14'd10000;
          default: fill = 14'($urandom_range((upper_q > 10000) ? 10000 : upper_q, 10000));
        endcase
        queue_req(brqs_pkg::ACT_DECIDE, $urandom(), fill, slot);
      end else if (pick < 95) begin
        rate = ($urandom_range(0, 9) == 0) ? $urandom()
             : slot * 32'd1500000 + $urandom_range(50000, 1500000);
        queue_req(brqs_pkg::ACT_LOAD, rate, fill, slot);
      end else begin
        queue_req(brqs_pkg::ACT_RESERVED, $urandom(), fill, slot);
      end
    end
  endtask

  // Stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: full ladder, zero-rate decisions, seeding, thresholds, step-up
    queue_req(brqs_pkg::ACT_LOAD, 32'd100000, 14'd0, 3'd0);
    queue_req(brqs_pkg::ACT_LOAD, 32'd300000, 14'd0, 3'd1);
    queue_req(brqs_pkg::ACT_LOAD, 32'd750000, 14'd0, 3'd2);
    queue_req(brqs_pkg::ACT_LOAD, 32'd1500000, 14'd0, 3'd3);
    queue_req(brqs_pkg::ACT_LOAD, 32'd3000000, 14'd0, 3'd4);
    queue_req(brqs_pkg::ACT_LOAD, 32'd6000000, 14'd0, 3'd5);
    queue_req(brqs_pkg::ACT_LOAD, 32'd12000000, 14'd0, 3'd6);
    queue_req(brqs_pkg::ACT_LOAD, 32'hFFFF_FFFF, 14'd10000, 3'd7);
    queue_req(brqs_pkg::ACT_DECIDE, 32'd0, 14'd0, 3'd0);
    queue_req(brqs_pkg::ACT_SAMPLE, 32'd0, 14'd0, 3'd0);
    queue_req(brqs_pkg::ACT_DECIDE, 32'd0, 14'd10000, 3'd0);
    queue_req(brqs_pkg::ACT_SAMPLE, 32'd8000000, 14'd0, 3'd0);
    queue_req(brqs_pkg::ACT_DECIDE, 32'd0, 14'd10000, 3'd0);
    queue_req(brqs_pkg::ACT_DECIDE, 32'd0, 14'd10000, 3'd0);
    queue_req(brqs_pkg::ACT_DECIDE, 32'd0, 14'd5000, 3'd0);
    queue_req(brqs_pkg::ACT_DECIDE, 32'd0, 14'd1999, 3'd0);
    queue_req(brqs_pkg::ACT_DECIDE, 32'd0, 14'd2000, 3'd0);
    queue_req(brqs_pkg::ACT_DECIDE, 32'd0, 14'd7999, 3'd0);
    queue_req(brqs_pkg::ACT_DECIDE, 32'd0, 14'd8000, 3'd0);
    queue_req(brqs_pkg::ACT_SAMPLE, 32'hFFFF_FFFF, 14'd0, 3'd7);
    queue_req(brqs_pkg::ACT_DECIDE, 32'd0, 14'd5000, 3'd0);
    queue_req(brqs_pkg::ACT_DECIDE, 32'd0, 14'd5000, 3'd0);
    queue_req(brqs_pkg::ACT_RESERVED, 32'hFFFF_FFFF, 14'd10000, 3'd7);
    queue_req(brqs_pkg::ACT_LOAD, 32'd0, 14'd0, 3'd7);
    queue_req(brqs_pkg::ACT_DECIDE, 32'd0, 14'd5000, 3'd0);
    queue_random(RANDOM_PER_SET);

    // Low extremes: no smoothing, wide slack, one level, zero step-up run count
    settle();
    set_regs(16'd0, 16'hFFFF, 16'd0, 16'd10000, 16'd0, 16'd1);
    queue_random(RANDOM_PER_SET);

    // High extremes: heavy smoothing, zero slack, crossed thresholds
    settle();
    set_regs(16'hFFFF, 16'd0, 16'd10000, 16'd0, 16'd255, 16'd8);
    queue_random(RANDOM_PER_SET);

    // Levels in use of zero
    settle();
    set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(1000, 12000)),
             16'($urandom_range(0, 5000)), 16'($urandom_range(5000, 10000)),
             16'($urandom_range(0, 6)), 16'd0);
    queue_random(RANDOM_PER_SET);

    // Levels in use beyond the ladder
    settle();
    set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
             16'($urandom_range(0, 10000)), 16'($urandom_range(0, 10000)),
             16'($urandom_range(0, 8)), 16'd15);
    queue_random(RANDOM_PER_SET);

    // Unity slack, random ladder depth
    settle();
    set_regs(16'($urandom_range(0, 65535)), 16'd4096, 16'($urandom_range(0, 4000)),
             16'($urandom_range(4000, 10000)), 16'd1, 16'($urandom_range(1, 8)));
    queue_random(RANDOM_PER_SET);

    // Typical operating point, shallow ladder
    settle();
    set_regs(16'd52429, 16'd4096, 16'd2000, 16'd8000, 16'd3, 16'd5);
    queue_random(RANDOM_PER_SET);

    settle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
